FILE: src/kesm_pkg.sv
`timescale 1ns / 1ps

package kesm_pkg;

	// Default sizes
	localparam int NUM_KEYS_DEF   = 3;
	localparam int FIFO_DEPTH_DEF = 16;

	// Fixed widths of the item, result, counter and configuration fields
	localparam int KEY_PRESSED_W = 3;
	localparam int EVENT_KEY_W   = 2;
	localparam int CNT_W         = 17;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 2;

	// Register reset values
	localparam logic [15:0] LONG_TIME_RST     = 16'd1000;
	localparam logic [15:0] REPEAT_PERIOD_RST = 16'd100;
	localparam logic [7:0]  TICK_STEP_RST     = 8'd1;
	localparam logic [3:0]  REPORT_MASK_RST   = 4'hF;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LONG_TIME     = 2'd0,
		CFG_REPEAT_PERIOD = 2'd1,
		CFG_TICK_STEP     = 2'd2,
		CFG_REPORT_MASK   = 2'd3
	} cfg_index_t;

	// Item kinds
	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_READ = 1'b1
	} item_kind_t;

	// Event codes
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_DOWN   = 3'd1,
		EV_UP     = 3'd2,
		EV_LONG   = 3'd3,
		EV_REPEAT = 3'd4
	} event_t;

	// Per-key debounce machine
	typedef enum logic [2:0] {
		KS_IDLE    = 3'd0,
		KS_DOWN    = 3'd1,
		KS_DOWN_OK = 3'd2,
		KS_UP      = 3'd3,
		KS_UP_OK   = 3'd4
	} key_state_t;

	typedef struct packed {
		logic                     kind;
		logic [KEY_PRESSED_W-1:0] key_pressed;
	} item_t;

	typedef struct packed {
		logic [2:0]             event_type;
		logic [EVENT_KEY_W-1:0] event_key;
		logic                   overflow;
	} result_t;

	typedef struct packed {
		event_t                 ev;
		logic [EVENT_KEY_W-1:0] key;
	} fifo_entry_t;

endpackage

FILE: src/key_event_state_machine.sv
`timescale 1ns / 1ps

// Debounce, long press and auto-repeat for NUM_KEYS keys with an event FIFO of
// FIFO_DEPTH entries. Takes one item per clock: a tick item steps every key
// machine in parallel and pushes its events (ascending key order, filtered by
// report_mask) and returns nothing; a read item pops one event and returns one
// result, type none when the FIFO is empty. Items land in an input register,
// all key machines and the multi-push FIFO update together from it, and a read
// result passes from the input register into the output register. The input
// side stalls only while a read waits in the input register behind a result
// that is still stalled. A push into a full FIFO is dropped and sets the
// sticky overflow bit returned with every result until reset. The user must
// write registers only while no item is in flight; the block does not enforce it.
module key_event_state_machine #(
	parameter int NUM_KEYS   = kesm_pkg::NUM_KEYS_DEF,
	parameter int FIFO_DEPTH = kesm_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  kesm_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output kesm_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [kesm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [kesm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);
	localparam int LV_W = (NUM_KEYS > kesm_pkg::KEY_PRESSED_W) ? NUM_KEYS :
		kesm_pkg::KEY_PRESSED_W;
	localparam int CW = kesm_pkg::CNT_W;

	// Configuration registers
	logic [15:0] long_time_q;
	logic [15:0] repeat_period_q;
	logic [7:0]  tick_step_q;
	logic [3:0]  report_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_time_q     <= kesm_pkg::LONG_TIME_RST;
			repeat_period_q <= kesm_pkg::REPEAT_PERIOD_RST;
			tick_step_q     <= kesm_pkg::TICK_STEP_RST;
			report_mask_q   <= kesm_pkg::REPORT_MASK_RST;
		end else if (cfg_we) begin
			unique case (kesm_pkg::cfg_index_t'(cfg_index))
				kesm_pkg::CFG_LONG_TIME:     long_time_q     <= cfg_data;
				kesm_pkg::CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				kesm_pkg::CFG_TICK_STEP:     tick_step_q     <= cfg_data[7:0];
				kesm_pkg::CFG_REPORT_MASK:   report_mask_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic                                  valid_s1;
	logic                                  kind_s1;
	logic [kesm_pkg::KEY_PRESSED_W-1:0]    levels_s1;
	logic                                  res_valid_q;
	kesm_pkg::result_t                     res_q;
	logic                                  tick_fire;
	logic                                  read_fire;
	logic                                  out_blocked;

	assign out_blocked = res_valid_q & result_stall;
	assign tick_fire   = valid_s1 & (kind_s1 == kesm_pkg::KIND_TICK);
	assign read_fire   = valid_s1 & (kind_s1 == kesm_pkg::KIND_READ) & ~out_blocked;
	assign item_stall  = valid_s1 & (kind_s1 == kesm_pkg::KIND_READ) & out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (tick_fire || read_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			kind_s1   <= item.kind;
			levels_s1 <= item.key_pressed;
		end
	end

	// Key machine state
	kesm_pkg::key_state_t key_state_q [NUM_KEYS];
	kesm_pkg::key_state_t key_state_d [NUM_KEYS];
	logic [NUM_KEYS-1:0]  prev_level_q;
	logic [NUM_KEYS-1:0]  prev_level_d;
	logic [CW-1:0]        hold_q [NUM_KEYS];
	logic [CW-1:0]        hold_d [NUM_KEYS];
	logic [CW-1:0]        rpt_q [NUM_KEYS];
	logic [CW-1:0]        rpt_d [NUM_KEYS];
	kesm_pkg::event_t     key_ev [NUM_KEYS];
	logic [LV_W-1:0]      lv_ext;

	assign lv_ext = LV_W'(levels_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_state_q[k] <= kesm_pkg::KS_IDLE;
				hold_q[k]      <= '0;
				rpt_q[k]       <= '0;
			end
		end else begin
			prev_level_q <= prev_level_d;
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_state_q[k] <= key_state_d[k];
				hold_q[k]      <= hold_d[k];
				rpt_q[k]       <= rpt_d[k];
			end
		end
	end

	// Next state and events for every key
	always_comb begin
		logic          lv;
		logic          same;
		logic [CW-1:0] hsum;
		logic [CW-1:0] rsum;
		prev_level_d = prev_level_q;
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_state_d[k] = key_state_q[k];
			hold_d[k]      = hold_q[k];
			rpt_d[k]       = rpt_q[k];
			key_ev[k]      = kesm_pkg::EV_NONE;
			lv             = lv_ext[k];
			same           = (lv == prev_level_q[k]);
			hsum           = hold_q[k] + CW'(tick_step_q);
			rsum           = rpt_q[k] + CW'(tick_step_q);
			if (tick_fire) begin
				prev_level_d[k] = lv;
				unique case (key_state_q[k])
					kesm_pkg::KS_IDLE: begin
						if (lv) key_state_d[k] = kesm_pkg::KS_DOWN;
					end
					kesm_pkg::KS_DOWN: begin
						if (same) begin
							key_state_d[k] = kesm_pkg::KS_DOWN_OK;
							key_ev[k]      = kesm_pkg::EV_DOWN;
						end else begin
							key_state_d[k] = kesm_pkg::KS_IDLE;
						end
					end
					kesm_pkg::KS_DOWN_OK: begin
						if (!same) begin
							key_state_d[k] = kesm_pkg::KS_UP;
						end else if (long_time_q != '0) begin
							if (hold_q[k] < CW'(long_time_q)) begin
								hold_d[k] = hsum;
								if (hsum >= CW'(long_time_q)) key_ev[k] = kesm_pkg::EV_LONG;
							end else if (repeat_period_q != '0) begin
								if (rsum >= CW'(repeat_period_q)) begin
									rpt_d[k]  = '0;
									key_ev[k] = kesm_pkg::EV_REPEAT;
								end else begin
									rpt_d[k] = rsum;
								end
							end
						end
					end
					kesm_pkg::KS_UP: begin
						if (same) begin
							key_state_d[k] = kesm_pkg::KS_UP_OK;
							hold_d[k]      = '0;
							rpt_d[k]       = '0;
							key_ev[k]      = kesm_pkg::EV_UP;
						end else begin
							key_state_d[k] = kesm_pkg::KS_DOWN_OK;
						end
					end
					kesm_pkg::KS_UP_OK: begin
						key_state_d[k] = same ? kesm_pkg::KS_IDLE : kesm_pkg::KS_UP;
					end
					default: key_state_d[k] = kesm_pkg::KS_IDLE;
				endcase
			end
		end
	end

	// Event FIFO
	kesm_pkg::fifo_entry_t fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [CNT_FW-1:0]     count_q;
	logic                  overflow_q;
	logic [NUM_KEYS-1:0]   push_en;
	logic [PTR_W-1:0]      push_addr [NUM_KEYS];
	logic [PTR_W-1:0]      wr_ptr_d;
	logic [CNT_FW-1:0]     cnt_after_push;
	logic                  ovf_set;
	logic                  pop;

	// Slot assignment for this tick's events, in ascending key order
	always_comb begin
		logic [PTR_W-1:0]  addr_run;
		logic [CNT_FW-1:0] cnt_run;
		logic              en;
		addr_run = wr_ptr_q;
		cnt_run  = count_q;
		ovf_set  = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			push_en[k]   = 1'b0;
			push_addr[k] = addr_run;
			unique case (key_ev[k])
				kesm_pkg::EV_DOWN:   en = report_mask_q[0];
				kesm_pkg::EV_UP:     en = report_mask_q[1];
				kesm_pkg::EV_LONG:   en = report_mask_q[2];
				kesm_pkg::EV_REPEAT: en = report_mask_q[3];
				default:             en = 1'b0;
			endcase
			if (en) begin
				if (cnt_run < CNT_FW'(FIFO_DEPTH)) begin
					push_en[k] = 1'b1;
					cnt_run    = cnt_run + 1'b1;
					addr_run   = (addr_run == PTR_W'(FIFO_DEPTH - 1)) ? '0 : addr_run + 1'b1;
				end else begin
					ovf_set = 1'b1;
				end
			end
		end
		wr_ptr_d       = addr_run;
		cnt_after_push = cnt_run;
	end

	assign pop = read_fire & (count_q != '0);

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (push_en[k]) begin
				fifo_mem[push_addr[k]].ev  <= key_ev[k];
				fifo_mem[push_addr[k]].key <= kesm_pkg::EVENT_KEY_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			// Ticks and reads never share a cycle
			if (tick_fire) begin
				wr_ptr_q <= wr_ptr_d;
				count_q  <= cnt_after_push;
				if (ovf_set) overflow_q <= 1'b1;
			end else if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (read_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_fire) begin
			res_q.overflow <= overflow_q;
			if (count_q == '0) begin
				res_q.event_type <= kesm_pkg::EV_NONE;
				res_q.event_key  <= '0;
			end else begin
				res_q.event_type <= fifo_mem[rd_ptr_q].ev;
				res_q.event_key  <= fifo_mem[rd_ptr_q].key;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
